@@ hdl/looped_ramped_pan_mixer_unit_macros.svh @@
// ----------------------------------------------------------------------------
// looped_ramped_pan_mixer_unit_macros
// assertion macros shared by the mixer rtl
// ----------------------------------------------------------------------------
// every macro samples on clk and is disabled while rst_n is low
`ifndef LOOPED_RAMPED_PAN_MIXER_UNIT_MACROS_SVH
`define LOOPED_RAMPED_PAN_MIXER_UNIT_MACROS_SVH

// condition holds at every edge
`define LPM_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LPM_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/lpm_pkg.sv @@
// ----------------------------------------------------------------------------
// lpm_pkg
// shared types and constants of the looped ramped pan mixer
// ----------------------------------------------------------------------------
package lpm_pkg;

  localparam int LOOP_DEPTH     = 65536;
  localparam int SAMPLE_BITS    = 16;
  localparam int LOOP_AW        = $clog2(LOOP_DEPTH);
  localparam int LEN_W          = LOOP_AW + 1;
  localparam int GAIN_W         = 17;
  localparam int PAN_W          = 18;
  localparam int ADDR_W         = 16;
  localparam int CFG_AW         = 2;
  localparam int CFG_DW         = 18;
  localparam int UNITY          = 65536;
  localparam int GAIN_THRESHOLD = 32;
  localparam int RAMP_RESET     = 73;
  localparam int SAT_LIMIT      = (98 * (2 ** (SAMPLE_BITS - 1)) + 50) / 100;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_TARGET_GAIN = 2'd0,
    REG_TARGET_PAN  = 2'd1,
    REG_RAMP_STEP   = 2'd2,
    REG_LOOP_LENGTH = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_MIX  = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  // classified item as it travels from front to back
  typedef struct packed {
    op_t                op;
    sample_t            mix_left;
    sample_t            mix_right;
    logic [LOOP_AW-1:0] addr;
    sample_t            data;
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [CFG_AW-1:0] addr;
    logic [CFG_DW-1:0] data;
  } cfg_wr_t;

endpackage

@@ hdl/lpm_if.sv @@
// ----------------------------------------------------------------------------
// lpm_if
// valid/ready channels of the mixer: input items and result items
// ----------------------------------------------------------------------------
interface lpm_in_if;
  logic                         valid;
  logic                         ready;
  logic                         operation;
  lpm_pkg::sample_t             mix_left;
  lpm_pkg::sample_t             mix_right;
  logic [lpm_pkg::ADDR_W-1:0]   load_address;
  lpm_pkg::sample_t             load_sample;

  modport source (output valid, operation, mix_left, mix_right, load_address, load_sample,
                  input ready);
  modport sink   (input valid, operation, mix_left, mix_right, load_address, load_sample,
                  output ready);
endinterface

interface lpm_out_if;
  logic             valid;
  logic             ready;
  lpm_pkg::sample_t out_left;
  lpm_pkg::sample_t out_right;
  logic             loop_audible;

  modport source (output valid, out_left, out_right, loop_audible, input ready);
  modport sink   (input valid, out_left, out_right, loop_audible, output ready);
endinterface

@@ hdl/lpm_front.sv @@
// ----------------------------------------------------------------------------
// lpm_front
// accepts input items, classifies them and holds one for the queue
// ----------------------------------------------------------------------------
module lpm_front (
  input  logic          clk,
  input  logic          rst_n,
  lpm_in_if.sink        in_chan,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output lpm_pkg::cmd_t cmd
);
  import lpm_pkg::*;

  logic hold_valid_r;
  logic hold_valid_nxt;
  cmd_t hold_r;
  cmd_t cls;
  logic keep;
  logic accept;

  assign in_chan.ready = !hold_valid_r || cmd_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign cmd_valid     = hold_valid_r;
  assign cmd           = hold_r;

  always_comb begin
    cls.op        = op_t'(in_chan.operation);
    cls.mix_left  = in_chan.mix_left;
    cls.mix_right = in_chan.mix_right;
    cls.addr      = LOOP_AW'(in_chan.load_address);
    cls.data      = in_chan.load_sample;
    // loads beyond the loop memory are swallowed here
    keep = !((cls.op == OP_LOAD) && (32'(in_chan.load_address) >= 32'(LOOP_DEPTH)));
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (cmd_ready) begin
      hold_valid_nxt = 1'b0;
    end
    if (accept) begin
      hold_valid_nxt = keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= cls;
    end
  end

endmodule

@@ hdl/lpm_queue.sv @@
// ----------------------------------------------------------------------------
// lpm_queue
// two-entry queue of classified items between front and back
// ----------------------------------------------------------------------------
module lpm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  lpm_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lpm_pkg::cmd_t pop_data
);
  import lpm_pkg::*;

  localparam int QD  = 2;
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  cmd_t           slot_r [QD];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW-1:0] rd_ptr_nxt;
  logic [QCW-1:0] count_r;
  logic [QCW-1:0] count_nxt;
  logic           push;
  logic           pop;

  assign push_ready = (count_r != QCW'(QD));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? QAW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QAW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = QCW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = QCW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/lpm_back.sv @@
// ----------------------------------------------------------------------------
// lpm_back
// carries out items: loop memory, gain and pan ramps, scaling, output register
// ----------------------------------------------------------------------------
`include "looped_ramped_pan_mixer_unit_macros.svh"

module lpm_back (
  input  logic             clk,
  input  logic             rst_n,
  input  lpm_pkg::cfg_wr_t cfg,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  lpm_pkg::cmd_t    cmd,
  lpm_out_if.source        out_chan
);
  import lpm_pkg::*;

  localparam int SLEW_W  = PAN_W + 2;
  localparam int SIDE_W  = GAIN_W + 1;
  localparam int PROD1_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int PROD2_W = PROD1_W + SIDE_W;
  localparam int SUM_W   = SAMPLE_BITS + 2;
  localparam logic signed [PROD2_W-1:0] ROUND_HALF = PROD2_W'(1) <<< 31;
  localparam logic signed [SUM_W-1:0]   SAT_HI     = SUM_W'(SAT_LIMIT);
  localparam logic signed [SUM_W-1:0]   SAT_LO     = SUM_W'(-SAT_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL1 = 4'b0010,
    S_MUL2 = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  function automatic logic signed [SLEW_W-1:0] slew(input logic signed [SLEW_W-1:0] now,
                                                    input logic signed [SLEW_W-1:0] tgt,
                                                    input logic signed [SLEW_W-1:0] step);
    logic signed [SLEW_W-1:0] up;
    logic signed [SLEW_W-1:0] dn;
    up = now + step;
    dn = now - step;
    if (now < tgt) begin
      return (up < tgt) ? up : tgt;
    end else if (now > tgt) begin
      return (dn > tgt) ? dn : tgt;
    end
    return now;
  endfunction

  function automatic sample_t sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

  // control state
  state_t                   state_r, state_nxt;
  logic [GAIN_W-1:0]        tgain_r, tgain_nxt;
  logic signed [PAN_W-1:0]  tpan_r, tpan_nxt;
  logic [GAIN_W-1:0]        step_r, step_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [LOOP_AW-1:0]       idx_r, idx_nxt;
  logic [GAIN_W-1:0]        gain_r, gain_nxt;
  logic signed [PAN_W-1:0]  pan_r, pan_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // payload
  sample_t                  loop_mem [LOOP_DEPTH];
  sample_t                  mem_q_r;
  logic                     audible_r;
  logic                     take_r;
  sample_t                  mixl_r;
  sample_t                  mixr_r;
  logic signed [PROD1_W-1:0] prod_r;
  logic signed [SIDE_W-1:0] lg_r;
  logic signed [SIDE_W-1:0] rg_r;
  logic signed [PROD2_W-1:0] pl_r;
  logic signed [PROD2_W-1:0] pr_r;
  sample_t                  outl_r;
  sample_t                  outr_r;
  logic                     outa_r;

  // datapath and decode
  logic                     cmd_pop;
  logic                     start_mix;
  logic                     mem_we;
  logic                     out_load;
  logic signed [SLEW_W-1:0] gain_slew;
  logic signed [SLEW_W-1:0] pan_slew;
  logic [GAIN_W-1:0]        gain_new;
  logic signed [PAN_W-1:0]  pan_new;
  logic                     aud_new;
  logic [LEN_W-1:0]         idx_inc;
  logic [LOOP_AW-1:0]       idx_wrap;
  sample_t                  sample_sel;
  logic signed [SIDE_W-1:0] gain_s;
  logic signed [SIDE_W-1:0] lg;
  logic signed [SIDE_W-1:0] rg;
  logic signed [PROD2_W-1:0] sum_l;
  logic signed [PROD2_W-1:0] sum_r;
  logic signed [PROD2_W-1:0] shf_l;
  logic signed [PROD2_W-1:0] shf_r;
  logic signed [SUM_W-1:0]  contrib_l;
  logic signed [SUM_W-1:0]  contrib_r;
  logic signed [SUM_W-1:0]  total_l;
  logic signed [SUM_W-1:0]  total_r;
  logic [GAIN_W-1:0]        cfg_gain;
  logic signed [PAN_W-1:0]  cfg_pan;
  logic [GAIN_W-1:0]        cfg_len;

  assign cmd_ready = (state_r == S_IDLE);
  assign cmd_pop   = cmd_valid && cmd_ready;
  assign start_mix = cmd_pop && (cmd.op == OP_MIX);

  // ramps and threshold
  always_comb begin
    gain_slew = slew($signed(SLEW_W'({1'b0, gain_r})), $signed(SLEW_W'({1'b0, tgain_r})),
                     $signed(SLEW_W'({1'b0, step_r})));
    pan_slew  = slew(SLEW_W'(pan_r), SLEW_W'(tpan_r), $signed(SLEW_W'({1'b0, step_r})));
    gain_new  = gain_slew[GAIN_W-1:0];
    pan_new   = pan_slew[PAN_W-1:0];
    aud_new   = (gain_new > GAIN_W'(GAIN_THRESHOLD));
    idx_inc   = LEN_W'(idx_r) + LEN_W'(1);
    idx_wrap  = (idx_inc == len_r) ? '0 : idx_inc[LOOP_AW-1:0];
  end

  // scaling and side gains
  always_comb begin
    sample_sel = take_r ? mem_q_r : '0;
    gain_s     = $signed({1'b0, gain_r});
    lg         = SIDE_W'(UNITY);
    rg         = SIDE_W'(UNITY);
    if (pan_r > 0) begin
      lg = SIDE_W'(PAN_W'(UNITY) - pan_r);
    end
    if (pan_r < 0) begin
      rg = SIDE_W'(PAN_W'(UNITY) + pan_r);
    end
    sum_l     = pl_r + ROUND_HALF;
    sum_r     = pr_r + ROUND_HALF;
    shf_l     = sum_l >>> 32;
    shf_r     = sum_r >>> 32;
    contrib_l = shf_l[SUM_W-1:0];
    contrib_r = shf_r[SUM_W-1:0];
    total_l   = SUM_W'(mixl_r) + contrib_l;
    total_r   = SUM_W'(mixr_r) + contrib_r;
  end

  // register write values with range clamps
  always_comb begin
    cfg_gain = cfg.data[GAIN_W-1:0];
    if (cfg_gain > GAIN_W'(UNITY)) begin
      cfg_gain = GAIN_W'(UNITY);
    end
    cfg_pan = $signed(cfg.data[PAN_W-1:0]);
    if (cfg_pan > PAN_W'(UNITY)) begin
      cfg_pan = PAN_W'(UNITY);
    end else if (cfg_pan < PAN_W'(-UNITY)) begin
      cfg_pan = PAN_W'(-UNITY);
    end
    cfg_len = cfg.data[GAIN_W-1:0];
  end

  always_comb begin
    state_nxt     = state_r;
    tgain_nxt     = tgain_r;
    tpan_nxt      = tpan_r;
    step_nxt      = step_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    gain_nxt      = gain_r;
    pan_nxt       = pan_r;
    out_valid_nxt = out_valid_r;
    mem_we        = 1'b0;
    out_load      = 1'b0;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (start_mix) begin
          gain_nxt = gain_new;
          pan_nxt  = pan_new;
          if (aud_new && (len_r != '0)) begin
            idx_nxt = idx_wrap;
          end
          state_nxt = S_MUL1;
        end else if (cmd_pop) begin
          mem_we = 1'b1;
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg.we) begin
      unique case (reg_idx_t'(cfg.addr))
        REG_TARGET_GAIN: tgain_nxt = cfg_gain;
        REG_TARGET_PAN:  tpan_nxt  = cfg_pan;
        REG_RAMP_STEP:   step_nxt  = cfg.data[GAIN_W-1:0];
        REG_LOOP_LENGTH: begin
          len_nxt = (32'(cfg_len) > 32'(LOOP_DEPTH)) ? LEN_W'(LOOP_DEPTH) : LEN_W'(cfg_len);
          idx_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tgain_r     <= '0;
      tpan_r      <= '0;
      step_r      <= GAIN_W'(RAMP_RESET);
      len_r       <= '0;
      idx_r       <= '0;
      gain_r      <= '0;
      pan_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tgain_r     <= tgain_nxt;
      tpan_r      <= tpan_nxt;
      step_r      <= step_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      gain_r      <= gain_nxt;
      pan_r       <= pan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // loop memory, registered read at the current loop index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      loop_mem[cmd.addr] <= cmd.data;
    end
    mem_q_r <= loop_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (start_mix) begin
      audible_r <= aud_new;
      take_r    <= aud_new && (len_r != '0);
      mixl_r    <= cmd.mix_left;
      mixr_r    <= cmd.mix_right;
    end
    if (state_r == S_MUL1) begin
      prod_r <= sample_sel * gain_s;
      lg_r   <= lg;
      rg_r   <= rg;
    end
    if (state_r == S_MUL2) begin
      pl_r <= prod_r * lg_r;
      pr_r <= prod_r * rg_r;
    end
    if (out_load) begin
      outl_r <= sat(total_l);
      outr_r <= sat(total_r);
      outa_r <= audible_r;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_left     = outl_r;
  assign out_chan.out_right    = outr_r;
  assign out_chan.loop_audible = outa_r;

  `LPM_ASSERT_IMPLIES(a_idx_in_loop, len_r != '0, LEN_W'(idx_r) < len_r, "loop index past length")
  `LPM_ASSERT_ALWAYS(a_gain_bounded, gain_r <= GAIN_W'(UNITY), "gain ramp above unity")
  `LPM_ASSERT_ALWAYS(a_pan_bounded, pan_r <= PAN_W'(UNITY) && pan_r >= PAN_W'(-UNITY), "pan range")
  `LPM_ASSERT_NEXT(a_mul_order, state_r == S_MUL1, state_r == S_MUL2, "multiply steps out of order")

endmodule

@@ hdl/looped_ramped_pan_mixer_unit.sv @@
// with no stalls a mix item passes the front holding register, a queue entry, the ramp
//   and memory read, two multiply steps and the output register before its result is valid
// the back sequencer takes no new item until a mix has reached the output register; loads are written while idle
// reset: synchronous active-low rst_n clears handshakes, queue, ramps and loop index,
//   and returns registers to their reset values; loop memory keeps its contents
// ----------------------------------------------------------------------------
// looped_ramped_pan_mixer_unit
// top level: stereo mixer adding a gain and pan ramped looped sample to the mix
// ----------------------------------------------------------------------------
module looped_ramped_pan_mixer_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  lpm_in_if.sink                    in_chan,
  lpm_out_if.source                 out_chan,
  input  logic                      cfg_we,
  input  logic [lpm_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [lpm_pkg::CFG_DW-1:0] cfg_wdata
);
  import lpm_pkg::*;

  // front holding register to queue
  logic    f_valid;
  logic    f_ready;
  cmd_t    f_cmd;

  // queue head to back
  logic    q_valid;
  logic    q_ready;
  cmd_t    q_cmd;

  // register write bundle, taken by the back part
  cfg_wr_t cfg;

  assign cfg.we   = cfg_we;
  assign cfg.addr = cfg_addr;
  assign cfg.data = cfg_wdata;

  // front: takes items, drops loads beyond the memory, holds one item
  lpm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // short queue so front and back stall on their own
  lpm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  // back: loop memory writes straight from idle, mix frames in the 4-step sequencer
  lpm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_chan  (out_chan)
  );

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// regression bench for the looped ramped pan mixer: gain and pan ramps,
// looped sample playback with wrap, panning and saturation, checked item by
// item against a scoreboard model under random idling and back pressure
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lpm_pkg::*;

  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int SETTLE_CYCLES = 16;   // block latency plus margin, loads included
  localparam int HOLD_CYCLES   = 300;  // long receiver hold-off, fills the block
  localparam longint ROUND_HALF = 64'sh8000_0000;

  // one input item as the bench sees it
  typedef struct {
    op_t               op;
    sample_t           mix_left;
    sample_t           mix_right;
    logic [ADDR_W-1:0] addr;
    sample_t           sample;
  } mixer_item_t;

  // one expected mix result
  typedef struct {
    sample_t left;
    sample_t right;
    logic    audible;
  } mix_frame_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  lpm_in_if  in_chan ();
  lpm_out_if out_chan ();

  looped_ramped_pan_mixer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // items waiting for the driver, results waiting for the block
  mixer_item_t pending_items [$];
  mix_frame_t  frame_results [$];

  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_seq       = 0;  // bumped by the stimulus to request a hold-off
  int hold_seen      = 0;
  int hold_left      = 0;
  bit in_taken       = 1'b0;

  // scoreboard copy of the mixer state and registers, reset values
  sample_t loop_mem [LOOP_DEPTH];
  longint  gain_level = 0;
  longint  pan_level  = 0;
  longint  loop_pos   = 0;
  longint  tgt_gain   = 0;
  longint  tgt_pan    = 0;
  longint  slew_step  = RAMP_RESET;
  longint  loop_len   = 0;

  // stimulus bookkeeping: which loop entries hold data, so no frame reads an
  // entry that was never loaded
  bit gen_written [LOOP_DEPTH];
  int gen_prefix    = 0;  // every entry below this one is loaded
  int gen_len       = 0;
  int gen_mix_since = 0;  // mix items queued since the last length write

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // scoreboard model
  // --------------------------------------------------------------------------
  function automatic longint slew_toward(input longint cur, input longint goal,
                                         input longint step);
    if (cur < goal) return (cur + step < goal) ? cur + step : goal;
    if (cur > goal) return (cur - step > goal) ? cur - step : goal;
    return cur;
  endfunction

  function automatic sample_t clip_sat(input longint v);
    if (v > SAT_LIMIT) return sample_t'(SAT_LIMIT);
    if (v < -SAT_LIMIT) return sample_t'(-SAT_LIMIT);
    return sample_t'(v);
  endfunction

  task automatic predict_item(input mixer_item_t it);
    longint lft;
    longint rgt;
    longint smp;
    longint lg;
    longint rg;
    longint idx;
    mix_frame_t res;
    // a load only fills memory, the 16 bit address is always inside it
    if (it.op == OP_LOAD) begin
      loop_mem[it.addr] = it.sample;
      return;
    end
    gain_level  = slew_toward(gain_level, tgt_gain, slew_step);
    pan_level   = slew_toward(pan_level, tgt_pan, slew_step);
    res.audible = (gain_level > GAIN_THRESHOLD);
    lft = it.mix_left;
    rgt = it.mix_right;
    if (res.audible) begin
      smp = 0;
      lg  = UNITY;
      rg  = UNITY;
      // empty loop plays silence but the frame still counts as audible
      if (loop_len != 0) begin
        idx      = loop_pos % loop_len;
        smp      = loop_mem[idx];
        loop_pos = (idx + 1) % loop_len;
      end
      // attenuate only the side away from the pan
      if (pan_level > 0) lg = UNITY - pan_level;
      if (pan_level < 0) rg = UNITY + pan_level;
      // round to nearest, ties up; arithmetic shift gives the floor
      lft += (smp * gain_level * lg + ROUND_HALF) >>> 32;
      rgt += (smp * gain_level * rg + ROUND_HALF) >>> 32;
    end
    res.left  = clip_sat(lft);
    res.right = clip_sat(rgt);
    frame_results.insert(frame_results.size(), res);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // input driver: changes on the falling edge, holds an item until taken
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : feed_items
    mixer_item_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_items.pop_front();
        in_chan.operation    <= nxt.op;
        in_chan.mix_left     <= nxt.mix_left;
        in_chan.mix_right    <= nxt.mix_right;
        in_chan.load_address <= nxt.addr;
        in_chan.load_sample  <= nxt.sample;
        in_chan.valid        <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result ready: random stalls, plus a counted hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : drain_results
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen      <= hold_seq;
      hold_left      <= HOLD_CYCLES;
      out_chan.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: checks results first, then predicts the item taken at this edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch_edges
    mix_frame_t  want;
    mixer_item_t took;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (frame_results.size() == 0) begin
          report_mismatch("result item with no expected frame");
        end else begin
          want = frame_results.pop_front();
          if (out_chan.out_left !== want.left)
            report_mismatch($sformatf("out_left %0d, expected %0d",
                                      out_chan.out_left, want.left));
          if (out_chan.out_right !== want.right)
            report_mismatch($sformatf("out_right %0d, expected %0d",
                                      out_chan.out_right, want.right));
          if (out_chan.loop_audible !== want.audible)
            report_mismatch($sformatf("loop_audible %0b, expected %0b",
                                      out_chan.loop_audible, want.audible));
        end
      end
      in_taken <= in_chan.valid && in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        took.op        = op_t'(in_chan.operation);
        took.mix_left  = in_chan.mix_left;
        took.mix_right = in_chan.mix_right;
        took.addr      = in_chan.load_address;
        took.sample    = in_chan.load_sample;
        predict_item(took);
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic sample_t rand_sample();
    case ($urandom_range(7))
      0:       return sample_t'(32767);
      1:       return sample_t'(-32768);
      2:       return sample_t'(0);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] rand_address();
    case ($urandom_range(3))
      0:       return '1;
      1:       return ADDR_W'($urandom);
      default: return ADDR_W'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic queue_load(input logic [ADDR_W-1:0] a, input sample_t s);
    mixer_item_t it;
    it.op        = OP_LOAD;
    it.addr      = a;
    it.sample    = s;
    it.mix_left  = sample_t'($urandom);  // ignored on a load
    it.mix_right = sample_t'($urandom);
    pending_items.insert(pending_items.size(), it);
    gen_written[a] = 1'b1;
  endtask

  // before a frame, make sure every entry it could read has been loaded;
  // the loop index can be at most the number of frames since the length write
  task automatic queue_mix(input sample_t l, input sample_t r);
    mixer_item_t it;
    int reach;
    if (gen_len != 0) begin
      reach = (gen_mix_since < gen_len) ? gen_mix_since : gen_len - 1;
      while (gen_prefix <= reach) begin
        if (!gen_written[gen_prefix]) queue_load(ADDR_W'(gen_prefix), rand_sample());
        gen_prefix++;
      end
    end
    gen_mix_since++;
    it.op        = OP_MIX;
    it.mix_left  = l;
    it.mix_right = r;
    it.addr      = ADDR_W'($urandom);     // don't care on a mix
    it.sample    = sample_t'($urandom);
    pending_items.insert(pending_items.size(), it);
  endtask

  // register write while idle; model registers follow after the write edge
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] val);
    longint v;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_TARGET_GAIN: begin
        v = val[GAIN_W-1:0];
        tgt_gain = (v > UNITY) ? UNITY : v;
      end
      REG_TARGET_PAN: begin
        v = longint'($signed(val[PAN_W-1:0]));
        if (v > UNITY) v = UNITY;
        if (v < -UNITY) v = -UNITY;
        tgt_pan = v;
      end
      REG_RAMP_STEP: begin
        slew_step = val[GAIN_W-1:0];
      end
      REG_LOOP_LENGTH: begin
        v = val[LEN_W-1:0];
        loop_len      = (v > LOOP_DEPTH) ? LOOP_DEPTH : v;
        loop_pos      = 0;  // length write restarts the loop
        gen_len       = int'(loop_len);
        gen_mix_since = 0;
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every item is taken and every result has come, then let the
  // block settle so a trailing load has finished too
  task automatic wait_idle();
    while (pending_items.size() != 0 || in_chan.valid || frame_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DW-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return CFG_DW'(UNITY);
      2:       return CFG_DW'($urandom_range(0, 2 * GAIN_THRESHOLD));  // near threshold
      3:       return CFG_DW'($urandom);                               // past unity too
      default: return CFG_DW'($urandom_range(0, UNITY));
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] pick_pan();
    case ($urandom_range(5))
      0:       return CFG_DW'(-UNITY);
      1:       return CFG_DW'(UNITY);
      2:       return '0;
      3:       return CFG_DW'($urandom);
      default: return CFG_DW'(int'($urandom_range(0, 2 * UNITY)) - UNITY);
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] pick_ramp();
    case ($urandom_range(6))
      0:       return '0;       // frozen ramps
      1:       return CFG_DW'(1);
      2:       return CFG_DW'(UNITY);
      3:       return CFG_DW'($urandom);
      default: return CFG_DW'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] pick_length();
    case ($urandom_range(6))
      0:       return '0;       // empty loop
      1:       return CFG_DW'(1);
      2:       return CFG_DW'(LOOP_DEPTH);
      3:       return CFG_DW'($urandom);  // may exceed the memory, clamps
      default: return CFG_DW'($urandom_range(2, 48));
    endcase
  endfunction

  task automatic random_config();
    write_reg(REG_TARGET_GAIN, pick_gain());
    write_reg(REG_TARGET_PAN, pick_pan());
    write_reg(REG_RAMP_STEP, pick_ramp());
    // sometimes keep the length so the loop runs on across settings
    if ($urandom_range(2) != 0) write_reg(REG_LOOP_LENGTH, pick_length());
  endtask

  // one random stretch under one setting and one idling pattern
  task automatic run_chunk(input int idle_pct, input int stall_pct, input int n_items,
                           input bit long_hold);
    int i;
    random_config();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 25) queue_load(rand_address(), rand_sample());
      else queue_mix(rand_sample(), rand_sample());
    end
    // receiver holds off while the sender keeps offering
    if (long_hold) hold_seq++;
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_addr             = '0;
    cfg_wdata            = '0;
    in_chan.valid        = 1'b0;
    in_chan.operation    = OP_MIX;
    in_chan.mix_left     = '0;
    in_chan.mix_right    = '0;
    in_chan.load_address = '0;
    in_chan.load_sample  = '0;
    out_chan.ready       = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: gain target zero, so frames pass the mix only
    queue_load(ADDR_W'(0), sample_t'(32767));
    queue_load(ADDR_W'(1), sample_t'(-32768));
    queue_load(ADDR_W'(2), sample_t'(0));
    queue_load(ADDR_W'(3), sample_t'(-1));
    queue_load('1, sample_t'(32767));          // top memory entry
    queue_mix(sample_t'(32767), sample_t'(-32768));  // clipped both ways
    queue_mix(sample_t'(0), sample_t'(0));
    wait_idle();

    // unity gain in one step, centered, four entry loop with wrap
    write_reg(REG_RAMP_STEP, CFG_DW'(UNITY));
    write_reg(REG_TARGET_GAIN, CFG_DW'(UNITY));
    write_reg(REG_LOOP_LENGTH, CFG_DW'(4));
    queue_mix(sample_t'(32767), sample_t'(32767));
    queue_mix(sample_t'(-32768), sample_t'(-32768));
    queue_mix(sample_t'(100), sample_t'(-100));
    queue_mix(sample_t'(0), sample_t'(0));
    queue_mix(sample_t'(1), sample_t'(-1));   // back at the first entry
    wait_idle();

    // full right pan silences the loop on the left
    write_reg(REG_TARGET_PAN, CFG_DW'(UNITY));
    queue_mix(sample_t'(-20000), sample_t'(20000));
    queue_mix(sample_t'(5), sample_t'(-5));
    wait_idle();

    // zero ramp step: gain and pan stay put whatever the targets say
    write_reg(REG_RAMP_STEP, '0);
    write_reg(REG_TARGET_GAIN, '0);
    write_reg(REG_TARGET_PAN, CFG_DW'(-UNITY));
    queue_mix(sample_t'(1000), sample_t'(-1000));
    queue_mix(sample_t'(-32768), sample_t'(32767));
    wait_idle();

    // targets and length past their ranges clamp
    write_reg(REG_RAMP_STEP, CFG_DW'(20000));
    write_reg(REG_TARGET_GAIN, CFG_DW'(18'h1ffff));
    write_reg(REG_TARGET_PAN, CFG_DW'(18'h20000));
    write_reg(REG_LOOP_LENGTH, CFG_DW'(18'h1ffff));
    repeat (4) queue_mix(rand_sample(), rand_sample());
    wait_idle();

    // empty loop: audible flag set, loop adds nothing
    write_reg(REG_LOOP_LENGTH, '0);
    queue_mix(sample_t'(12345), sample_t'(-12345));
    queue_mix(sample_t'(32767), sample_t'(-32768));
    wait_idle();

    // gain just above, then exactly at the threshold
    write_reg(REG_LOOP_LENGTH, CFG_DW'(4));
    write_reg(REG_RAMP_STEP, CFG_DW'(UNITY));
    write_reg(REG_TARGET_GAIN, CFG_DW'(GAIN_THRESHOLD + 1));
    queue_mix(sample_t'(0), sample_t'(0));
    wait_idle();
    write_reg(REG_TARGET_GAIN, CFG_DW'(GAIN_THRESHOLD));
    queue_mix(sample_t'(0), sample_t'(0));
    wait_idle();

    // random part: free flow, sender gaps, receiver stalls, both
    repeat (2) run_chunk(0, 0, 50, 1'b0);
    repeat (2) run_chunk(48, 0, 50, 1'b0);
    repeat (2) run_chunk(0, 48, 50, 1'b0);
    repeat (2) run_chunk(36, 36, 50, 1'b0);
    // back pressure: long hold-off with the sender never idle
    run_chunk(0, 20, 55, 1'b1);
    run_chunk(0, 0, 45, 1'b1);

    wait_idle();
    if (mismatches == 0) begin
      $display("looped_ramped_pan_mixer_unit regression: pass");
    end else begin
      $display("looped_ramped_pan_mixer_unit regression: fail");
    end
    $finish;
  end

  // watchdog for a hung handshake or lost results
  initial begin
    #(TIMEOUT_NS);
    $display("looped_ramped_pan_mixer_unit regression: fail");
    $finish;
  end

endmodule
